// File: hw/rtl/stack_bytecode_executor_assert.svh
`ifndef STACK_BYTECODE_EXECUTOR_ASSERT_SVH
`define STACK_BYTECODE_EXECUTOR_ASSERT_SVH

// same-cycle implication
`define SBX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SBX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/sbx_pkg.sv
package sbx_pkg;

    typedef logic [7:0] opcode_t;

    localparam opcode_t OP_NOP        = 8'd0;
    localparam opcode_t OP_PUSH       = 8'd1;
    localparam opcode_t OP_ADD        = 8'd2;
    localparam opcode_t OP_SUB        = 8'd3;
    localparam opcode_t OP_MUL        = 8'd4;
    localparam opcode_t OP_DIV        = 8'd5;
    localparam opcode_t OP_MOD        = 8'd6;
    localparam opcode_t OP_LOAD       = 8'd7;
    localparam opcode_t OP_STORE      = 8'd8;
    localparam opcode_t OP_JMP        = 8'd9;
    localparam opcode_t OP_JZ         = 8'd10;
    localparam opcode_t OP_JNZ        = 8'd11;
    localparam opcode_t OP_CALL       = 8'd12;
    localparam opcode_t OP_RET        = 8'd13;
    localparam opcode_t OP_POP        = 8'd14;
    localparam opcode_t OP_PRINT      = 8'd15;
    localparam opcode_t OP_STRLEN     = 8'd16;
    localparam opcode_t OP_EQ         = 8'd17;
    localparam opcode_t OP_NE         = 8'd18;
    localparam opcode_t OP_GT         = 8'd19;
    localparam opcode_t OP_LT         = 8'd20;
    localparam opcode_t OP_GE         = 8'd21;
    localparam opcode_t OP_LE         = 8'd22;
    localparam opcode_t OP_NOT        = 8'd23;
    localparam opcode_t OP_ORD        = 8'd24;
    localparam opcode_t OP_PUSH_STR   = 8'd25;
    localparam opcode_t OP_GET_INT    = 8'd26;
    localparam opcode_t OP_STREQ      = 8'd28;
    localparam opcode_t OP_CONCAT     = 8'd29;
    localparam opcode_t OP_GET        = 8'd30;
    localparam opcode_t OP_SET        = 8'd31;
    localparam opcode_t OP_DICT_HAS   = 8'd32;
    localparam opcode_t OP_IS_NUM     = 8'd33;
    localparam opcode_t OP_IS_STR     = 8'd34;
    localparam opcode_t OP_IS_LIST    = 8'd35;
    localparam opcode_t OP_SAME       = 8'd36;
    localparam opcode_t OP_LIST_CCAT  = 8'd37;
    localparam opcode_t OP_LIST_NEW   = 8'd39;
    localparam opcode_t OP_LIST_GET   = 8'd40;
    localparam opcode_t OP_SLICE      = 8'd41;
    localparam opcode_t OP_LIST_LEN   = 8'd42;
    localparam opcode_t OP_DICT_LEN   = 8'd43;
    localparam opcode_t OP_DICT_GET   = 8'd44;
    localparam opcode_t OP_DICT       = 8'd45;
    localparam opcode_t OP_INPUT      = 8'd46;
    localparam opcode_t OP_REPLACE    = 8'd47;
    localparam opcode_t OP_STR_FIND   = 8'd48;
    localparam opcode_t OP_TO_INT     = 8'd49;
    localparam opcode_t OP_STR_LIST   = 8'd50;
    localparam opcode_t OP_JMP_FAR    = 8'd51;
    localparam opcode_t OP_OR         = 8'd52;
    localparam opcode_t OP_AND        = 8'd53;
    localparam opcode_t OP_READ_FILE  = 8'd54;
    localparam opcode_t OP_DICT_KEYS  = 8'd55;
    localparam opcode_t OP_STARTSWITH = 8'd56;
    localparam opcode_t OP_CONTAINS   = 8'd57;
    localparam opcode_t OP_WRITE_OUT  = 8'd58;
    localparam opcode_t OP_HALT       = 8'hFF;

    localparam logic [7:0] CFG_CODE_LEN  = 8'd0;
    localparam logic [7:0] CFG_INIT_VARS = 8'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CALL_OVF = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_STACK    = 3'd3,
        ST_UNSUP    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] npop;
        logic       npush;
        status_t    status;
    } dec_t;

    typedef struct packed {
        logic start;
        logic want_rem;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

    function automatic logic [31:0] truth(input logic c);
        return c ? 32'd1 : 32'hFFFF_FFFF;
    endfunction

    function automatic dec_t decode(input opcode_t op);
        dec_t d;
        d = '{npop: 2'd0, npush: 1'b0, status: ST_OK};
        case (op)
            OP_NOP, OP_JMP, OP_JMP_FAR, OP_CALL, OP_RET, OP_HALT: ;
            OP_PUSH, OP_LOAD: d.npush = 1'b1;
            OP_STORE, OP_JZ, OP_JNZ, OP_POP: d.npop = 2'd1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_GT, OP_LT,
            OP_GE, OP_LE, OP_OR, OP_AND, OP_STREQ, OP_GET, OP_DICT_HAS, OP_SAME,
            OP_LIST_CCAT, OP_LIST_GET, OP_DICT_GET, OP_STR_FIND, OP_READ_FILE,
            OP_STARTSWITH, OP_CONTAINS: begin
                d.npop  = 2'd2;
                d.npush = 1'b1;
            end
            OP_NOT, OP_GET_INT, OP_IS_NUM, OP_IS_STR, OP_IS_LIST, OP_LIST_LEN,
            OP_DICT_LEN, OP_INPUT, OP_TO_INT, OP_WRITE_OUT, OP_PRINT, OP_STRLEN,
            OP_ORD: begin
                d.npop  = 2'd1;
                d.npush = 1'b1;
            end
            OP_SET: d.npop = 2'd3;
            OP_SLICE, OP_REPLACE: begin
                d.npop  = 2'd3;
                d.npush = 1'b1;
            end
            OP_DICT, OP_PUSH_STR, OP_LIST_NEW, OP_CONCAT, OP_DICT_KEYS, OP_STR_LIST:
                d.status = ST_UNSUP;
            default: d.status = ST_UNKNOWN;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/sbx_alu.sv
module sbx_alu (
    input  sbx_pkg::opcode_t op,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    input  logic [31:0]      imm,
    output logic [31:0]      r
);
    import sbx_pkg::*;

    logic slt_ab;
    logic slt_ba;

    assign slt_ab = $signed(a) < $signed(b);
    assign slt_ba = $signed(b) < $signed(a);

    always_comb begin
        case (op)
            OP_PUSH:   r = imm;
            OP_ADD:    r = a + b;
            OP_SUB:    r = a - b;
            OP_MUL:    r = a * b;
            OP_EQ:     r = truth(a == b);
            OP_NE:     r = truth(a != b);
            OP_GT:     r = truth(slt_ba);
            OP_LT:     r = truth(slt_ab);
            OP_GE:     r = truth(!slt_ab);
            OP_LE:     r = truth(!slt_ba);
            OP_OR:     r = truth(a != 32'd0 || b != 32'd0);
            OP_AND:    r = truth(a != 32'd0 && b != 32'd0);
            OP_NOT:    r = truth(b == 32'd0);
            OP_SAME:   r = truth(a == b);
            OP_STREQ, OP_IS_NUM, OP_STARTSWITH, OP_CONTAINS: r = 32'd1;
            OP_IS_STR, OP_IS_LIST, OP_DICT_HAS: r = 32'hFFFF_FFFF;
            default:   r = 32'd0;
        endcase
    end

endmodule

// File: hw/rtl/sbx_div.sv
module sbx_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sbx_pkg::div_req_t req,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output sbx_pkg::div_rsp_t rsp,
    output logic [31:0]       result
);
    import sbx_pkg::*;

    localparam int W  = 32;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  mb_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          neg_q_reg;
    logic          neg_r_reg;
    logic          want_rem_reg;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  quo_next;

    always_comb begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, mb_reg};
        if (!diff[W]) begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg     <= 1'b1;
            done_reg     <= 1'b0;
            cnt_reg      <= CW'(W);
            rem_reg      <= '0;
            quo_reg      <= a[W-1] ? (W'(0) - a) : a;
            mb_reg       <= b[W-1] ? (W'(0) - b) : b;
            neg_q_reg    <= a[W-1] ^ b[W-1];
            neg_r_reg    <= a[W-1];
            want_rem_reg <= req.want_rem;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;

    always_comb begin
        if (want_rem_reg) begin
            result = neg_r_reg ? (W'(0) - rem_reg) : rem_reg;
        end else begin
            result = neg_q_reg ? (W'(0) - quo_reg) : quo_reg;
        end
    end

endmodule

// File: hw/rtl/stack_bytecode_executor.sv
// DIV and MOD with a nonzero divisor wait in S_DIV while the bit-serial divider runs.
// Throughput: one instruction in flight; the next is accepted once the current one
// reaches the output register, and S_FIN holds it while the previous output is not taken;
// the operand stack memory has one read port.
// Reset (aresetn low, synchronous): clears stack pointer, frame depth, halt flag, status,
// code length and valid bits; no clearing pass, the block is ready at once.
`include "stack_bytecode_executor_assert.svh"

module stack_bytecode_executor #(
    parameter  int STACK_DEPTH = 512,
    parameter  int VAR_SLOTS   = 256,
    parameter  int FRAME_DEPTH = 64,
    localparam int SP_W        = $clog2(STACK_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_req_type,
    input  logic signed [31:0] s_immediate,
    input  logic [7:0]        s_byte_operand,
    input  logic [31:0]       s_fallthrough_pc,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_next_pc,
    output logic              m_halted,
    output logic [2:0]        m_status,
    output logic signed [31:0] m_top_value,
    output logic [SP_W-1:0]   m_stack_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import sbx_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int VW   = $clog2(VAR_SLOTS);
    localparam int FAW  = $clog2(FRAME_DEPTH);
    localparam int FDW  = $clog2(FRAME_DEPTH + 1);
    localparam int FE_W = 32 + SP_W;
    localparam logic [8:0] VAR_LIM = 9'(VAR_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_EXEC, S_LOAD, S_DIV, S_WB, S_TOP, S_RET, S_FIN
    } state_t;

    state_t          state_reg;
    opcode_t         op_reg;
    logic [31:0]     imm_reg;
    logic [7:0]      bop_reg;
    logic [31:0]     npc_reg;
    logic [31:0]     r_reg;
    status_t         status_reg;
    logic [SP_W-1:0] sp_reg;
    logic [31:0]     top_reg;
    logic [FDW-1:0]  fd_reg;
    logic            halt_reg;
    logic [8:0]      defcnt_reg;
    logic [31:0]     code_len_reg;
    logic [VAR_SLOTS-1:0] var_valid_reg;

    logic            m_valid_reg;
    logic [31:0]     m_next_pc_reg;
    logic            m_halted_reg;
    logic [2:0]      m_status_reg;
    logic [31:0]     m_top_reg;
    logic [SP_W-1:0] m_count_reg;

    logic [31:0]     stack_mem [STACK_DEPTH];
    logic [31:0]     stack_rdata_reg;
    logic [31:0]     var_mem [VAR_SLOTS];
    logic [31:0]     var_rdata_reg;
    logic [FE_W-1:0] frame_mem [FRAME_DEPTH];
    logic [FE_W-1:0] frame_rdata_reg;

    dec_t            dec;
    logic [31:0]     a_val;
    logic [31:0]     b_val;
    logic [SP_W-1:0] sp_after;
    logic [SP_W-1:0] sp_m2;
    logic [SP_W-1:0] sp_after_m1;
    logic [AW-1:0]   stk_raddr;
    logic            stk_we;
    logic [AW-1:0]   stk_waddr;
    logic [31:0]     stk_wdata;
    logic            var_we;
    logic            frame_we;
    logic [FDW-1:0]  fd_m1;
    logic            pre_fault;
    logic            stk_fault;
    logic            call_ovf;
    logic            call_arg;
    logic            bop_in;
    logic            is_div;
    logic            out_free;
    logic            halt_fin;
    logic [SP_W-1:0] fr_base;
    logic [31:0]     fr_pc;
    logic            ret_ok;
    logic [31:0]     ret_val;
    logic [31:0]     alu_r;
    logic [31:0]     div_result;
    div_req_t        div_req;
    div_rsp_t        div_rsp;

    sbx_alu u_alu (
        .op  (op_reg),
        .a   (a_val),
        .b   (b_val),
        .imm (imm_reg),
        .r   (alu_r)
    );

    sbx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .a       (a_val),
        .b       (b_val),
        .rsp     (div_rsp),
        .result  (div_result)
    );

    always_comb begin
        dec         = decode(op_reg);
        b_val       = (dec.npop != 2'd0) ? top_reg : 32'd0;
        a_val       = (dec.npop >= 2'd2) ? stack_rdata_reg : 32'd0;
        sp_after    = SP_W'(32'(sp_reg) - 32'(dec.npop) + 32'(dec.npush));
        sp_m2       = sp_reg - SP_W'(2);
        sp_after_m1 = sp_after - SP_W'(1);
        fd_m1       = fd_reg - FDW'(1);
        fr_base     = frame_rdata_reg[SP_W-1:0];
        fr_pc       = frame_rdata_reg[FE_W-1:SP_W];
        ret_ok      = 32'(fr_base) < 32'(STACK_DEPTH);
        ret_val     = (sp_reg > fr_base) ? top_reg : 32'd0;
        pre_fault   = dec.status != ST_OK;
        stk_fault   = (32'(dec.npop) > 32'(sp_reg)) ||
                      ((32'(sp_reg) - 32'(dec.npop) + 32'(dec.npush)) > 32'(STACK_DEPTH));
        call_ovf    = 32'(fd_reg) >= 32'(FRAME_DEPTH);
        call_arg    = 32'(bop_reg) > 32'(sp_reg);
        bop_in      = {1'b0, bop_reg} < VAR_LIM;
        is_div      = (op_reg == OP_DIV) || (op_reg == OP_MOD);
        out_free    = !m_valid_reg || m_ready;
        halt_fin    = halt_reg || (npc_reg >= code_len_reg);

        div_req.start    = (state_reg == S_EXEC) && is_div && (b_val != 32'd0);
        div_req.want_rem = op_reg == OP_MOD;

        stk_raddr = (state_reg == S_WB) ? sp_after_m1[AW-1:0] : sp_m2[AW-1:0];
        stk_we    = 1'b0;
        stk_waddr = sp_after_m1[AW-1:0];
        stk_wdata = r_reg;
        if (state_reg == S_WB && dec.npush) begin
            stk_we = 1'b1;
        end else if (state_reg == S_RET && ret_ok) begin
            stk_we    = 1'b1;
            stk_waddr = fr_base[AW-1:0];
            stk_wdata = ret_val;
        end

        var_we   = (state_reg == S_CHECK) && !halt_reg && !pre_fault && !stk_fault &&
                   (op_reg == OP_STORE) && bop_in;
        frame_we = (state_reg == S_CHECK) && !halt_reg && !pre_fault && !stk_fault &&
                   (op_reg == OP_CALL) && !call_ovf && !call_arg;
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stack_rdata_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (var_we) begin
            var_mem[bop_reg[VW-1:0]] <= top_reg;
        end
        var_rdata_reg <= var_mem[bop_reg[VW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[fd_reg[FAW-1:0]] <= {npc_reg, SP_W'(32'(sp_reg) - 32'(bop_reg))};
        end
        frame_rdata_reg <= frame_mem[fd_m1[FAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            fd_reg        <= '0;
            halt_reg      <= 1'b0;
            defcnt_reg    <= '0;
            code_len_reg  <= '0;
            var_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            status_reg    <= ST_OK;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CODE_LEN) begin
                    code_len_reg <= cfg_data;
                end else if (cfg_index == CFG_INIT_VARS) begin
                    defcnt_reg <= {1'b0, cfg_data[7:0]};
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_req_type;
                        imm_reg    <= s_immediate;
                        bop_reg    <= s_byte_operand;
                        npc_reg    <= s_fallthrough_pc;
                        status_reg <= ST_OK;
                        state_reg  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (halt_reg) begin
                        state_reg <= S_FIN;
                    end else if (pre_fault) begin
                        status_reg <= dec.status;
                        halt_reg   <= 1'b1;
                        state_reg  <= S_FIN;
                    end else if (stk_fault) begin
                        status_reg <= ST_STACK;
                        halt_reg   <= 1'b1;
                        state_reg  <= S_FIN;
                    end else if (op_reg == OP_CALL) begin
                        priority if (call_ovf) begin
                            status_reg <= ST_CALL_OVF;
                            halt_reg   <= 1'b1;
                        end else if (call_arg) begin
                            status_reg <= ST_STACK;
                            halt_reg   <= 1'b1;
                        end else begin
                            fd_reg  <= fd_reg + FDW'(1);
                            npc_reg <= imm_reg;
                        end
                        state_reg <= S_FIN;
                    end else if (op_reg == OP_RET) begin
                        if (fd_reg == '0) begin
                            halt_reg  <= 1'b1;
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= S_RET;
                        end
                    end else if (op_reg == OP_HALT) begin
                        halt_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end else if (op_reg == OP_LOAD) begin
                        state_reg <= S_LOAD;
                    end else if (op_reg == OP_STORE) begin
                        if (bop_in) begin
                            var_valid_reg[bop_reg[VW-1:0]] <= 1'b1;
                            if ({1'b0, bop_reg} >= defcnt_reg) begin
                                defcnt_reg <= {1'b0, bop_reg} + 9'd1;
                            end
                        end
                        state_reg <= S_WB;
                    end else begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_reg <= alu_r;
                    if (op_reg == OP_JMP || op_reg == OP_JMP_FAR) begin
                        npc_reg <= imm_reg;
                    end else if (op_reg == OP_JZ && b_val == 32'd0) begin
                        npc_reg <= imm_reg;
                    end else if (op_reg == OP_JNZ && b_val != 32'd0) begin
                        npc_reg <= imm_reg;
                    end
                    state_reg <= div_req.start ? S_DIV : S_WB;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_reg     <= div_result;
                        state_reg <= S_WB;
                    end
                end
                S_LOAD: begin
                    r_reg <= (bop_in && ({1'b0, bop_reg} < defcnt_reg) &&
                              var_valid_reg[bop_reg[VW-1:0]]) ? var_rdata_reg : 32'd0;
                    state_reg <= S_WB;
                end
                S_WB: begin
                    sp_reg <= sp_after;
                    priority if (dec.npush) begin
                        top_reg   <= r_reg;
                        state_reg <= S_FIN;
                    end else if (dec.npop == 2'd0 || sp_after == '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_TOP;
                    end
                end
                S_TOP: begin
                    top_reg   <= stack_rdata_reg;
                    state_reg <= S_FIN;
                end
                S_RET: begin
                    if (!ret_ok) begin
                        status_reg <= ST_STACK;
                        halt_reg   <= 1'b1;
                    end else begin
                        fd_reg  <= fd_m1;
                        sp_reg  <= fr_base + SP_W'(1);
                        top_reg <= ret_val;
                        npc_reg <= fr_pc;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_next_pc_reg <= npc_reg;
                        m_halted_reg  <= halt_fin;
                        m_status_reg  <= status_reg;
                        m_top_reg     <= (sp_reg != '0) ? top_reg : 32'd0;
                        m_count_reg   <= sp_reg;
                        halt_reg      <= halt_fin;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready       = state_reg == S_IDLE;
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_next_pc     = m_next_pc_reg;
    assign m_halted      = m_halted_reg;
    assign m_status      = m_status_reg;
    assign m_top_value   = m_top_reg;
    assign m_stack_count = m_count_reg;

    `SBX_ASSERT_NOW(a_sp_bound, aclk, aresetn, 1'b1, 32'(sp_reg) <= 32'(STACK_DEPTH))
    `SBX_ASSERT_NOW(a_fd_bound, aclk, aresetn, 1'b1, 32'(fd_reg) <= 32'(FRAME_DEPTH))
    `SBX_ASSERT_NEXT(a_halt_sticky, aclk, aresetn, halt_reg, halt_reg)
    `SBX_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SBX_ASSERT_NOW(a_defcnt_bound, aclk, aresetn, 1'b1, defcnt_reg <= 9'd256)

endmodule
